// ===== sv/logistic_neuron_trainer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Logistic neuron trainer assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LOGISTIC_NEURON_TRAINER_UNIT_ASSERT_SVH
`define LOGISTIC_NEURON_TRAINER_UNIT_ASSERT_SVH

// same-cycle implication
`define LNT_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LNT_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/lnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Logistic neuron trainer package
// Widths, state and register codes, sigmoid and log tables, rounding helpers.
// ----------------------------------------------------------------------------
package lnt_pkg;

  localparam int SIG_DEPTH = 256;
  localparam int LOG_DEPTH = 256;
  localparam int COUNT_W   = 16;
  localparam int SIG_IW    = $clog2(SIG_DEPTH);
  localparam int LOG_IW    = $clog2(LOG_DEPTH);
  localparam int LOG_W     = 20;
  localparam int PROD_W    = 60;
  localparam int SUM_W     = 48;
  localparam int CFG_W     = 19;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 144;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam longint unsigned ONE_Q32  = 64'd4294967296;
  localparam longint unsigned EINV_Q32 = 64'd1580030169;
  localparam longint unsigned LN2_Q32  = 64'd2977044472;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_RATE  = 3'd1,
    CFG_BIAS  = 3'd2,
    CFG_MASS  = 3'd3,
    CFG_SPEED = 3'd4
  } cfg_idx_t;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_M1    = 15'h0002,
    S_M2    = 15'h0004,
    S_NET   = 15'h0008,
    S_SIG   = 15'h0010,
    S_G     = 15'h0020,
    S_GS    = 15'h0040,
    S_MS    = 15'h0080,
    S_SS    = 15'h0100,
    S_E1    = 15'h0200,
    S_E2    = 15'h0400,
    S_ACC   = 15'h0800,
    S_CLOSE = 15'h1000,
    S_DIV   = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic [15:0]      sig_tab_t [SIG_DEPTH];
  typedef logic [LOG_W-1:0] log_tab_t [LOG_DEPTH];

  // shift and subtract quotient for table building
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned t);
    longint unsigned n;
    longint unsigned f;
    longint unsigned e;
    longint          term;
    longint          sum;
    n    = t >> 16;
    f    = t & 64'hFFFF;
    term = longint'(ONE_Q32);
    sum  = term;
    for (int i = 1; i <= 12; i++) begin
      term = longint'(udiv64(longint'(unsigned'(term)) * f, 64'd65536 * 64'(i)));
      sum  = ((i & 1) != 0) ? sum - term : sum + term;
    end
    e = longint'(unsigned'(sum));
    for (longint unsigned j = 0; j < n; j++) begin
      e = (e * EINV_Q32 + (64'd1 << 31)) >> 32;
    end
    return e;
  endfunction

  function automatic sig_tab_t build_sig();
    sig_tab_t        tab;
    longint          x;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      x = -524288 + longint'((64'd1048576 * (2 * longint'(k) + 1)) >> (SIG_IW + 1));
      if (x >= 0) begin
        e   = exp_neg(longint'(unsigned'(x)));
        den = ONE_Q32 + e;
        s   = udiv64((64'd1 << 48) + (den >> 1), den);
      end else begin
        e   = exp_neg(longint'(unsigned'(-x)));
        den = ONE_Q32 + e;
        s   = udiv64((e << 16) + (den >> 1), den);
      end
      if (s < 1) s = 1;
      if (s > 65535) s = 65535;
      tab[k] = 16'(s);
    end
    return tab;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t        tab;
    longint unsigned v;
    longint unsigned s;
    longint unsigned f;
    longint unsigned nl2;
    for (int k = 0; k < LOG_DEPTH; k++) begin
      v = ((2 * longint'(k) + 1) << 31) >> (LOG_IW + 1);
      s = 0;
      f = 0;
      while (v < (64'd1 << 31)) begin
        v = v << 1;
        s = s + 1;
      end
      for (int i = 0; i < 16; i++) begin
        v = (v * v) >> 31;
        f = f << 1;
        if (v >= (64'd1 << 32)) begin
          v = v >> 1;
          f = f | 64'd1;
        end
      end
      nl2    = s * 64'd65536 - f;
      tab[k] = LOG_W'((nl2 * LN2_Q32 + (64'd1 << 31)) >> 32);
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig();
  localparam log_tab_t LOG_TAB = build_log();

  // round half away from zero
  function automatic logic signed [PROD_W-1:0] rsr(logic signed [PROD_W-1:0] v, int s);
    logic signed [PROD_W-1:0] h;
    h = PROD_W'(1) <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -50'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat48(logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) return {1'b0, {(SUM_W-1){1'b1}}};
    if (v < -50'sh0_8000_0000_0000) return {1'b1, {(SUM_W-1){1'b0}}};
    return SUM_W'(v);
  endfunction

endpackage

// ===== sv/lnt_div.sv =====
// ----------------------------------------------------------------------------
// Epoch error divider
// Restoring divide of the error sum by the sample count, one bit per cycle.
// ----------------------------------------------------------------------------
module lnt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lnt_pkg::SUM_W-1:0]    dividend,
  input  logic [lnt_pkg::COUNT_W-1:0]  divisor,
  output logic [lnt_pkg::SUM_W-1:0]    quotient,
  output lnt_pkg::div_stat_t           stat
);
  import lnt_pkg::*;

  logic [SUM_W-1:0]   quo_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] dvs_r;
  logic [DIV_CW-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [COUNT_W:0]   trial;
  logic               ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? COUNT_W'(trial - {1'b0, dvs_r}) : COUNT_W'(trial);
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/logistic_neuron_trainer_unit.sv =====
// ----------------------------------------------------------------------------
// Logistic neuron trainer
// Two-input sigmoid neuron with bias, trained one sample per input word.
// ----------------------------------------------------------------------------
// Input words carry a sample (mass, speed, target) with tlast marking the
// last sample of an epoch, or a restart (tuser high) that reloads the
// initial weights from the configuration registers and clears the sums.
// Each input word gives exactly one output word: prediction, epoch error
// and the three weights after the update, with tlast set on epoch close.
// One signed multiplier serves every product under a one-hot sequencer, so
// a word is taken only while the sequencer is idle. A training word passes
// through S_M1, S_M2, S_NET, S_SIG, S_G, S_GS, S_MS, S_SS, S_E1, S_ACC and
// S_FIN, with S_E2 added in batch mode and S_CLOSE when it closes an epoch;
// a restart goes straight to S_FIN. The next word is taken back in S_IDLE.
// A batch epoch close adds the bit-serial division of the error sum by the
// sample count; S_FIN holds the word until the output register is free.
// Config writes are registered; the user makes them only while idle, and
// the block does not enforce it. Reset clears weights, sums, count and the
// output valid flag. A finished word waits in the output register; the next
// input word is taken meanwhile and its result holds until the receiver
// takes the first.
`include "logistic_neuron_trainer_unit_assert.svh"

module logistic_neuron_trainer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lnt_pkg::IN_W-1:0]    in_tdata,  // mass, speed, target, zero pad
  input  logic                        in_tuser,  // operation
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lnt_pkg::OUT_W-1:0]   out_tdata, // prediction, epoch_error,
                                                 // bias, mass, speed weights
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [lnt_pkg::CFG_W-1:0]   cfg_wdata
);
  import lnt_pkg::*;

  state_t                     state_r;
  logic                       mode_r;
  logic [15:0]                rate_r;
  logic signed [CFG_W-1:0]    ibias_r;
  logic signed [CFG_W-1:0]    imass_r;
  logic signed [CFG_W-1:0]    ispeed_r;
  logic signed [31:0]         wb_r;
  logic signed [31:0]         wm_r;
  logic signed [31:0]         ws_r;
  logic signed [SUM_W-1:0]    bsum_r;
  logic signed [SUM_W-1:0]    msum_r;
  logic signed [SUM_W-1:0]    ssum_r;
  logic [SUM_W-1:0]           err_r;
  logic [COUNT_W-1:0]         cnt_r;
  logic signed [23:0]         mass_r;
  logic signed [23:0]         speed_r;
  logic [12:0]                tgt_r;
  logic                       last_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   acc_r;
  logic [15:0]                pred_r;
  logic signed [17:0]         d_r;
  logic signed [34:0]         g_r;
  logic signed [17:0]         sb_r;
  logic [23:0]                add_r;
  logic                       done_r;
  logic [31:0]                eerr_r;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r;
  logic                       out_last_r;

  logic signed [34:0]         mul_a;
  logic signed [24:0]         mul_b;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [17:0]         d_c;
  logic [16:0]                qinv;
  logic [LOG_W-1:0]           lp;
  logic [LOG_W-1:0]           lq;
  logic                       net_in;
  logic [31:0]                net_off;
  logic [SIG_IW-1:0]          sig_idx;
  logic signed [49:0]         sm50;
  logic signed [49:0]         ss50;
  logic [SUM_W:0]             err_add;
  logic                       out_free;
  logic                       div_start;
  logic [SUM_W-1:0]           div_quo;
  div_stat_t                  div_stat;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign div_start = (state_r == S_CLOSE) && mode_r;

  assign d_c     = $signed({1'b0, tgt_r, 4'b0}) - $signed({2'b00, pred_r});
  assign qinv    = 17'h10000 - {1'b0, pred_r};
  assign lp      = LOG_TAB[pred_r[15 -: LOG_IW]];
  assign lq      = LOG_TAB[qinv[15 -: LOG_IW]];
  assign net_in  = (acc_r[PROD_W-1:31] == '0) || (acc_r[PROD_W-1:31] == '1);
  assign net_off = {~acc_r[31], acc_r[30:0]};
  assign sig_idx = !net_in ? (acc_r[PROD_W-1] ? '0 : '1) : net_off[31 -: SIG_IW];
  assign sm50    = 50'(rsr(prod_r, 28));
  assign ss50    = 50'(rsr(prod_r, 28));
  assign err_add = (SUM_W+1)'(err_r) + (SUM_W+1)'(add_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M1: begin
        mul_a = 35'(wm_r);
        mul_b = 25'(mass_r);
      end
      S_M2: begin
        mul_a = 35'(ws_r);
        mul_b = 25'(speed_r);
      end
      S_G: begin
        mul_a = $signed(35'(rate_r));
        mul_b = 25'(d_c);
      end
      S_GS: begin
        mul_a = prod_r[34:0];
        mul_b = 25'(mass_r);
      end
      S_MS: begin
        mul_a = g_r;
        mul_b = 25'(speed_r);
      end
      S_SS: begin
        if (mode_r) begin
          mul_a = $signed(35'(lp));
          mul_b = $signed(25'(tgt_r));
        end else begin
          mul_a = 35'(d_r);
          mul_b = 25'(d_r);
        end
      end
      S_E1: begin
        mul_a = $signed(35'(lq));
        mul_b = $signed(25'(13'd4096 - tgt_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      rate_r   <= 16'd6554;
      ibias_r  <= '0;
      imass_r  <= '0;
      ispeed_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r   <= cfg_wdata[0];
        CFG_RATE:  rate_r   <= cfg_wdata[15:0];
        CFG_BIAS:  ibias_r  <= cfg_wdata;
        CFG_MASS:  imass_r  <= cfg_wdata;
        CFG_SPEED: ispeed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wb_r        <= '0;
      wm_r        <= '0;
      ws_r        <= '0;
      bsum_r      <= '0;
      msum_r      <= '0;
      ssum_r      <= '0;
      err_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_FIN)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mass_r  <= in_tdata[23:0];
            speed_r <= in_tdata[47:24];
            tgt_r   <= (in_tdata[60:48] > 13'd4096) ? 13'd4096 : in_tdata[60:48];
            last_r  <= in_tlast;
            pred_r  <= '0;
            done_r  <= 1'b0;
            eerr_r  <= '0;
            if (in_tuser) begin
              wb_r   <= 32'(ibias_r);
              wm_r   <= 32'(imass_r);
              ws_r   <= 32'(ispeed_r);
              bsum_r <= '0;
              msum_r <= '0;
              ssum_r <= '0;
              err_r  <= '0;
              cnt_r  <= '0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_M1;
            end
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          acc_r   <= prod_r;
          state_r <= S_NET;
        end
        S_NET: begin
          acc_r   <= acc_r + prod_r - (PROD_W'(wb_r) <<< 12);
          state_r <= S_SIG;
        end
        S_SIG: begin
          pred_r  <= SIG_TAB[sig_idx];
          state_r <= S_G;
        end
        S_G: begin
          d_r     <= d_c;
          state_r <= S_GS;
        end
        S_GS: begin
          g_r     <= prod_r[34:0];
          sb_r    <= 18'(rsr(prod_r, 16));
          state_r <= S_MS;
        end
        S_MS: begin
          if (mode_r) begin
            bsum_r <= sat48(50'(bsum_r) - 50'(sb_r));
            msum_r <= sat48(50'(msum_r) + sm50);
          end else begin
            wb_r <= sat32(50'(wb_r) - 50'(sb_r));
            wm_r <= sat32(50'(wm_r) + sm50);
          end
          state_r <= S_SS;
        end
        S_SS: begin
          if (mode_r) ssum_r <= sat48(50'(ssum_r) + ss50);
          else ws_r <= sat32(50'(ws_r) + ss50);
          state_r <= S_E1;
        end
        S_E1: begin
          if (mode_r) begin
            acc_r   <= prod_r;
            state_r <= S_E2;
          end else begin
            add_r   <= 24'(rsr(prod_r, 17));
            state_r <= S_ACC;
          end
        end
        S_E2: begin
          add_r   <= 24'(rsr(acc_r + prod_r, 12));
          state_r <= S_ACC;
        end
        S_ACC: begin
          err_r <= err_add[SUM_W] ? '1 : err_add[SUM_W-1:0];
          if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
          state_r <= last_r ? S_CLOSE : S_FIN;
        end
        S_CLOSE: begin
          done_r <= 1'b1;
          if (mode_r) begin
            wb_r    <= sat32(50'(wb_r) + 50'(bsum_r));
            wm_r    <= sat32(50'(wm_r) + 50'(msum_r));
            ws_r    <= sat32(50'(ws_r) + 50'(ssum_r));
            state_r <= S_DIV;
          end else begin
            eerr_r  <= (err_r[SUM_W-1:32] != '0) ? '1 : err_r[31:0];
            state_r <= S_FIN;
          end
          bsum_r <= '0;
          msum_r <= '0;
          ssum_r <= '0;
          err_r  <= '0;
          cnt_r  <= '0;
        end
        S_DIV: begin
          if (div_stat.done) begin
            eerr_r  <= (div_quo[SUM_W-1:32] != '0) ? '1 : div_quo[31:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {ws_r, wm_r, wb_r, eerr_r, pred_r};
            out_last_r  <= done_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  lnt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (err_r),
    .divisor  (cnt_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `LNT_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_r == S_DIV, "divider done outside divide")
  `LNT_ASSERT_NXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != S_IDLE, "accept kept idle")
  `LNT_ASSERT_IMP(a_close_has_count, state_r == S_CLOSE, cnt_r != '0, "epoch close with empty count")
  `LNT_ASSERT_IMP(a_error_only_on_close, state_r == S_FIN, done_r || (eerr_r == '0), "error without close")

endmodule

// ===== tb/logistic_neuron_trainer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logistic neuron trainer testbench
// Drives training and restart words through the stream ports under several
// register settings and idle patterns, predicts each output word with an
// independent fixed point model of the neuron, and compares field by field.
// ----------------------------------------------------------------------------
module logistic_neuron_trainer_unit_test;
  import lnt_pkg::*;

  localparam int  END_HOLD   = 80;
  localparam int  STALL_MAX  = 4000;
  localparam int  PHASES     = 6;
  localparam int  PHASE_WORDS = 308;
  localparam logic OP_TRAIN   = 1'b0;
  localparam logic OP_RESTART = 1'b1;
  localparam longint W_MAX  = 64'sd2147483647;
  localparam longint W_MIN  = -64'sd2147483648;
  localparam longint S48_LIM = 64'sd1 <<< 47;
  localparam longint unsigned ERR_MAX = (64'd1 << 48) - 1;

  typedef struct {
    logic [15:0]        prediction;
    logic               epoch_done;
    logic [31:0]        epoch_error;
    logic signed [31:0] bias_w;
    logic signed [31:0] mass_w;
    logic signed [31:0] speed_w;
  } neuron_word_t;

  typedef struct {
    logic               op;
    logic signed [23:0] mass;
    logic signed [23:0] speed;
    logic [12:0]        target;
    logic               last;
    logic               typed;
  } sample_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;  // mass, speed, target, zero pad
  logic               in_tuser;  // operation
  logic               in_tlast;  // last_in_epoch
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata; // prediction, epoch_error, bias, mass, speed
  logic               out_tlast; // epoch_done
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  logistic_neuron_trainer_unit dut (.*);

  longint unsigned sigmoid_lut [256];
  longint unsigned neg_log_lut [256];

  logic        mode_r;
  logic [15:0] rate_r;
  logic [18:0] init_bias_r, init_mass_r, init_speed_r;
  longint      bias_w, mass_w, speed_w;
  longint      bias_acc, mass_acc, speed_acc;
  longint unsigned err_acc;
  int          sample_cnt;

  neuron_word_t pending_words [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned exp_q32(longint unsigned t);
    longint unsigned whole, frac, e;
    longint term, acc;
    whole = t >> 16;
    frac  = t & 64'hFFFF;
    term  = 64'sd4294967296;
    acc   = term;
    for (int i = 1; i <= 12; i++) begin
      term = longint'((unsigned'(term) * frac) / (64'd65536 * i));
      acc  = (i % 2 == 1) ? acc - term : acc + term;
    end
    e = unsigned'(acc);
    for (longint unsigned j = 0; j < whole; j++)
      e = (e * 64'd1580030169 + (64'd1 << 31)) >> 32;
    return e;
  endfunction

  task automatic fill_luts();
    longint x;
    longint unsigned e, den, s, v, sh, fr, nl2;
    for (int k = 0; k < 256; k++) begin
      x = -524288 + longint'((64'd1048576 * (2 * k + 1)) / 512);
      e = exp_q32((x >= 0) ? unsigned'(x) : unsigned'(-x));
      den = 64'd4294967296 + e;
      s = (x >= 0) ? ((64'd1 << 48) + den / 2) / den : ((e << 16) + den / 2) / den;
      if (s < 1) s = 1;
      if (s > 65535) s = 65535;
      sigmoid_lut[k] = s;
      v = ((64'd2 * k + 1) << 31) / 512;
      sh = 0;
      fr = 0;
      while (v < (64'd1 << 31)) begin
        v = v << 1;
        sh++;
      end
      for (int i = 0; i < 16; i++) begin
        v = (v * v) >> 31;
        fr = fr << 1;
        if (v >= (64'd1 << 32)) begin
          v = v >> 1;
          fr = fr | 1;
        end
      end
      nl2 = sh * 65536 - fr;
      neg_log_lut[k] = (nl2 * 64'd2977044472 + (64'd1 << 31)) >> 32;
    end
  endtask

  function automatic longint round_shift(longint v, int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic longint clamp_w(longint v);
    return (v > W_MAX) ? W_MAX : (v < W_MIN) ? W_MIN : v;
  endfunction

  function automatic longint clamp_acc(longint v);
    return (v > S48_LIM - 1) ? S48_LIM - 1 : (v < -S48_LIM) ? -S48_LIM : v;
  endfunction

  function automatic longint unsigned neg_log(longint unsigned p);
    return neg_log_lut[(p * 256) >> 16];
  endfunction

  function automatic void clear_epoch();
    bias_acc = 0;
    mass_acc = 0;
    speed_acc = 0;
    err_acc = 0;
    sample_cnt = 0;
  endfunction

  function automatic neuron_word_t train_neuron(sample_row_t r);
    neuron_word_t w;
    longint m, s, t, net, d, g, sb, sm, ss, idx;
    longint unsigned p, add, ee;
    w = '{default: '0};
    if (r.op == OP_RESTART) begin
      bias_w  = longint'($signed(init_bias_r));
      mass_w  = longint'($signed(init_mass_r));
      speed_w = longint'($signed(init_speed_r));
      clear_epoch();
    end else begin
      m = r.mass;
      s = r.speed;
      t = (r.target > 4096) ? 4096 : r.target;
      net = m * mass_w + s * speed_w - bias_w * 4096;
      if (net < -(64'sd8 <<< 28)) idx = 0;
      else if (net >= (64'sd8 <<< 28)) idx = 255;
      else idx = ((net + (64'sd8 <<< 28)) * 256) >>> 32;
      p = sigmoid_lut[idx];
      w.prediction = p[15:0];
      d  = t * 16 - longint'(p);
      g  = longint'(rate_r) * d;
      sb = round_shift(g, 16);
      sm = round_shift(g * m, 28);
      ss = round_shift(g * s, 28);
      if (!mode_r) begin
        bias_w  = clamp_w(bias_w - sb);
        mass_w  = clamp_w(mass_w + sm);
        speed_w = clamp_w(speed_w + ss);
        add = round_shift(d * d, 17);
      end else begin
        bias_acc  = clamp_acc(bias_acc - sb);
        mass_acc  = clamp_acc(mass_acc + sm);
        speed_acc = clamp_acc(speed_acc + ss);
        add = round_shift(longint'(t * neg_log(p) + (4096 - t) * neg_log(65536 - p)), 12);
      end
      err_acc += add;
      if (err_acc > ERR_MAX) err_acc = ERR_MAX;
      if (sample_cnt < 65535) sample_cnt++;
      if (r.last) begin
        w.epoch_done = 1'b1;
        if (mode_r) begin
          bias_w  = clamp_w(bias_w + bias_acc);
          mass_w  = clamp_w(mass_w + mass_acc);
          speed_w = clamp_w(speed_w + speed_acc);
          ee = err_acc / sample_cnt;
        end else begin
          ee = err_acc;
        end
        if (ee > 64'hFFFF_FFFF) ee = 64'hFFFF_FFFF;
        w.epoch_error = ee[31:0];
        clear_epoch();
      end
    end
    w.bias_w  = bias_w[31:0];
    w.mass_w  = mass_w[31:0];
    w.speed_w = speed_w[31:0];
    return w;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [18:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE:  mode_r = val[0];
      CFG_RATE:  rate_r = val[15:0];
      CFG_BIAS:  init_bias_r = val;
      CFG_MASS:  init_mass_r = val;
      CFG_SPEED: init_speed_r = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (END_HOLD) @(posedge clk);
  endtask

  task automatic send_sample(sample_row_t r);
    neuron_word_t w;
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b0, r.target, r.speed, r.mass};
    in_tuser  <= r.op;
    in_tlast  <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    w = train_neuron(r);
    if (r.typed) w = '{default: '0};
    pending_words.push_back(w);
  endtask

  function automatic logic signed [23:0] rand_feature();
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic sample_row_t rand_sample();
    sample_row_t r;
    int k;
    r.typed = 1'b0;
    r.op = ($urandom_range(0, 99) < 3) ? OP_RESTART : OP_TRAIN;
    r.mass = rand_feature();
    r.speed = rand_feature();
    k = $urandom_range(0, 99);
    r.target = (k < 85) ? 13'($urandom_range(0, 4096)) : (k < 90) ? 13'd4096 :
               13'($urandom);
    r.last = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  sample_row_t opening_rows [] = '{
    '{OP_RESTART, 24'sd0, 24'sd0, 13'd0, 1'b0, 1'b1},
    '{OP_TRAIN, 24'sd0, 24'sd0, 13'd0, 1'b0, 1'b0},
    '{OP_TRAIN, 24'sd8388607, 24'sd0, 13'd4096, 1'b0, 1'b0},
    '{OP_TRAIN, -24'sd8388608, 24'sd8388607, 13'd0, 1'b0, 1'b0},
    '{OP_TRAIN, 24'sd0, -24'sd8388608, 13'd8191, 1'b1, 1'b0},
    '{OP_RESTART, 24'sd0, 24'sd0, 13'd0, 1'b0, 1'b1},
    '{OP_TRAIN, 24'sd4096, 24'sd4096, 13'd2048, 1'b0, 1'b0},
    '{OP_TRAIN, -24'sd4096, 24'sd8192, 13'd4095, 1'b0, 1'b0},
    '{OP_RESTART, 24'sd8388607, -24'sd1, 13'd8191, 1'b1, 1'b1},
    '{OP_TRAIN, 24'sd8388607, 24'sd8388607, 13'd4096, 1'b1, 1'b0},
    '{OP_TRAIN, 24'sd100, -24'sd100, 13'd0, 1'b1, 1'b0},
    '{OP_TRAIN, -24'sd8388608, -24'sd8388608, 13'd1, 1'b0, 1'b0},
    '{OP_TRAIN, 24'sd12345, -24'sd6789, 13'd3000, 1'b1, 1'b0},
    '{OP_TRAIN, -24'sd1, 24'sd1, 13'd5000, 1'b1, 1'b0}
  };

  logic        ph_mode  [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [15:0] ph_rate  [PHASES] = '{16'd65535, 16'd6554, 16'd0, 16'd1, 16'd65535, 16'd20000};
  int          ph_bias  [PHASES] = '{196608, -196608, 0, 0, 65536, -1};
  int          ph_mass  [PHASES] = '{-196608, 196608, 4096, 0, -65536, 1};
  int          ph_speed [PHASES] = '{0, 65536, -4096, 0, 196608, -196608};

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    neuron_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_tdata[15:0] !== e.prediction) begin
          $error("prediction exp %0d got %0d", e.prediction, out_tdata[15:0]);
          errors++;
        end
        if (out_tlast !== e.epoch_done) begin
          $error("epoch_done exp %0d got %0d", e.epoch_done, out_tlast);
          errors++;
        end
        if (out_tdata[47:16] !== e.epoch_error) begin
          $error("epoch_error exp %0d got %0d", e.epoch_error, out_tdata[47:16]);
          errors++;
        end
        if (out_tdata[79:48] !== e.bias_w) begin
          $error("bias_gain exp %0d got %0d", e.bias_w, $signed(out_tdata[79:48]));
          errors++;
        end
        if (out_tdata[111:80] !== e.mass_w) begin
          $error("mass_gain exp %0d got %0d", e.mass_w, $signed(out_tdata[111:80]));
          errors++;
        end
        if (out_tdata[143:112] !== e.speed_w) begin
          $error("speed_gain exp %0d got %0d", e.speed_w, $signed(out_tdata[143:112]));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MODE;
    cfg_wdata = '0;
    fill_luts();
    mode_r = 1'b0;
    rate_r = 16'd6554;
    init_bias_r = '0;
    init_mass_r = '0;
    init_speed_r = '0;
    bias_w = 0;
    mass_w = 0;
    speed_w = 0;
    clear_epoch();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_rows[i]) send_sample(opening_rows[i]);
    in_tvalid <= 1'b0;
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle = (ph < 2) ? 27 : (ph < 4) ? 84 : 0;
      recv_idle = (ph < 2) ? 84 : (ph < 4) ? 27 : 0;
      write_reg(CFG_MODE, 19'(ph_mode[ph]));
      write_reg(CFG_RATE, 19'(ph_rate[ph]));
      write_reg(CFG_BIAS, (ph == 2) ? 19'($urandom) : 19'(ph_bias[ph]));
      write_reg(CFG_MASS, (ph == 2) ? 19'($urandom) : 19'(ph_mass[ph]));
      write_reg(CFG_SPEED, (ph == 2) ? 19'($urandom) : 19'(ph_speed[ph]));
      cfg_we <= 1'b0;
      for (int n = 0; n < PHASE_WORDS; n++) send_sample(rand_sample());
      in_tvalid <= 1'b0;
      drain();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
